// ----- design/deadzone_scroll_tracker_defines.svh -----
// Assertion macros shared by the deadzone scroll tracker RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef DEADZONE_SCROLL_TRACKER_DEFINES_SVH
`define DEADZONE_SCROLL_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DZST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DZST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/dzst_pkg.sv -----
// Types and constants of the deadzone scroll tracker.
// No dependencies; used by the channel interfaces, the axis unit and the top level.
package dzst_pkg;

   localparam int COORD_W  = 16;   // signed 12.4 world coordinate
   localparam int PIX_W    = 12;   // integer pixel part
   localparam int SCROLL_W = 11;
   localparam int TILE_W   = 8;
   localparam int SPAN_W   = 5;
   localparam int KIND_W   = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 8;
   localparam int CALC_W   = 16;   // signed working width of the follow math

   localparam int OFFSET_X = 8;
   localparam int OFFSET_Y = 16;

   localparam logic [TILE_W-1:0] EDGE_COL_ADD = 8'd20;
   localparam logic [TILE_W-1:0] EDGE_ROW_ADD = 8'd18;
   localparam logic [SPAN_W-1:0] COLUMN_ROWS  = 5'd19;
   localparam logic [SPAN_W-1:0] ROW_COLS     = 5'd21;
   localparam logic [SPAN_W-1:0] UNIT_SPAN    = 5'd1;

   localparam logic [CSR_DATA_W-1:0] MARGIN_RESET = 8'd20;
   localparam logic [CSR_DATA_W-1:0] MAP_RESET    = 8'd32;

   localparam logic [CSR_IDX_W-1:0] REG_MARGIN_LEFT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MARGIN_RIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MARGIN_TOP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MARGIN_BOTTOM = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_WIDTH     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_HEIGHT    = 3'd5;

   typedef enum logic [KIND_W-1:0] {
      KIND_COLUMN = 2'd0,
      KIND_ROW    = 2'd1,
      KIND_SCROLL = 2'd2
   } kind_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] near_margin;
      logic [CSR_DATA_W-1:0] far_margin;
      logic [CSR_DATA_W-1:0] map_tiles;
   } axis_cfg_type;

endpackage

// ----- design/dzst_req_if.sv -----
// Input channel of the deadzone scroll tracker: object world position.
// Depends on dzst_pkg.
interface dzst_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [dzst_pkg::COORD_W-1:0] world_x;
   logic signed [dzst_pkg::COORD_W-1:0] world_y;

   modport source (output valid, output world_x, output world_y, input ready);
   modport sink   (input valid, input world_x, input world_y, output ready);
endinterface

// ----- design/dzst_rsp_if.sv -----
// Result channel of the deadzone scroll tracker: load requests and scroll updates.
// Depends on dzst_pkg.
interface dzst_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [dzst_pkg::KIND_W-1:0]     result_kind;
   logic [dzst_pkg::TILE_W-1:0]     region_col;
   logic [dzst_pkg::TILE_W-1:0]     region_row;
   logic [dzst_pkg::SPAN_W-1:0]     region_cols;
   logic [dzst_pkg::SPAN_W-1:0]     region_rows;
   logic [dzst_pkg::SCROLL_W-1:0]   scroll_x;
   logic [dzst_pkg::SCROLL_W-1:0]   scroll_y;
   logic                            last;

   modport source (output valid, output result_kind, output region_col, output region_row,
                   output region_cols, output region_rows, output scroll_x,
                   output scroll_y, output last, input ready);
   modport sink   (input valid, input result_kind, input region_col, input region_row,
                   input region_cols, input region_rows, input scroll_x,
                   input scroll_y, input last, output ready);
endinterface

// ----- design/dzst_axis.sv -----
// One axis of the deadzone follow rule with clamping to the map extent.
// Depends on dzst_pkg.
module dzst_axis #(
   parameter int SCREEN = 160,
   parameter int OFFSET = 8
) (
   input  logic signed [dzst_pkg::PIX_W-1:0]    pix,
   input  logic [dzst_pkg::SCROLL_W-1:0]        cam,
   input  dzst_pkg::axis_cfg_type               cfg,
   output logic [dzst_pkg::SCROLL_W-1:0]        cam_next
);
   import dzst_pkg::*;

   localparam logic signed [CALC_W-1:0] SCREEN_S = CALC_W'(SCREEN);
   localparam logic signed [CALC_W-1:0] OFFSET_S = CALC_W'(OFFSET);

   logic signed [CALC_W-1:0] pix_s;
   logic signed [CALC_W-1:0] cam_s;
   logic signed [CALC_W-1:0] near_s;
   logic signed [CALC_W-1:0] far_edge;
   logic signed [CALC_W-1:0] draw;
   logic signed [CALC_W-1:0] moved;
   logic signed [CALC_W-1:0] limit_raw;
   logic signed [CALC_W-1:0] limit;

   assign pix_s     = {{(CALC_W-PIX_W){pix[PIX_W-1]}}, pix};
   assign cam_s     = {{(CALC_W-SCROLL_W){1'b0}}, cam};
   assign near_s    = {{(CALC_W-CSR_DATA_W){1'b0}}, cfg.near_margin};
   assign far_edge  = SCREEN_S - {{(CALC_W-CSR_DATA_W){1'b0}}, cfg.far_margin};
   assign draw      = pix_s - cam_s - OFFSET_S;
   assign limit_raw = {{(CALC_W-CSR_DATA_W-3){1'b0}}, cfg.map_tiles, 3'b000} - SCREEN_S;
   assign limit     = (limit_raw < 0) ? '0 : limit_raw;

   always_comb begin
      // far edge wins when the margins cross
      if (draw > far_edge) begin
         moved = pix_s - OFFSET_S - far_edge;
      end else if (draw < near_s) begin
         moved = pix_s - OFFSET_S - near_s;
      end else begin
         moved = cam_s;
      end
      if (moved < 0) begin
         cam_next = '0;
      end else if (moved > limit) begin
         cam_next = limit[SCROLL_W-1:0];
      end else begin
         cam_next = moved[SCROLL_W-1:0];
      end
   end
endmodule

// ----- design/deadzone_scroll_tracker.sv -----
// Channel    | Dir | Payload                                          | Accepted when
// req        | in  | world_x, world_y (signed 12.4)                   | valid && ready
// rsp        | out | result_kind, region_*, scroll_x/y, last          | valid && ready
// csr        | in  | csr_index (3b), csr_wdata (8b)                   | csr_we
//
// An accepted transaction lands in the input register; from there the scroll follow
// math loads the result group register once it is empty or issuing its final result,
// and that register then issues 1 to 3 result transactions, one per cycle while rsp.ready
// is high; the result group register is the pacing point.
// Synchronous active-high reset restores the margins, the map size and a zero scroll.
// Back-pressure on rsp holds the group, then the input register, then req.ready.
//
// Depends on dzst_pkg, dzst_req_if, dzst_rsp_if, dzst_axis and the defines header.
`include "deadzone_scroll_tracker_defines.svh"

module deadzone_scroll_tracker #(
   parameter int SCREEN_W = 160,
   parameter int SCREEN_H = 144
) (
   input  logic                                clock,
   input  logic                                reset,
   dzst_req_if.sink                            req,
   dzst_rsp_if.source                          rsp,
   input  logic                                csr_we,
   input  logic [dzst_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dzst_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import dzst_pkg::*;

   // configuration
   logic [CSR_DATA_W-1:0] margin_left_ff, margin_right_ff, margin_top_ff, margin_bottom_ff;
   logic [CSR_DATA_W-1:0] map_width_ff, map_height_ff;

   // input register
   logic                      in_valid_ff;
   logic signed [COORD_W-1:0] in_x_ff, in_y_ff;

   // scroll state and result group
   logic [SCROLL_W-1:0] cam_x_ff, cam_y_ff;
   logic [SCROLL_W-1:0] cam_x_in, cam_y_in;
   logic                grp_valid_ff;
   logic                col_pend_ff, row_pend_ff;
   logic [TILE_W-1:0]   load_col_ff, load_row_ff;
   logic [TILE_W-1:0]   load_col_in, load_row_in;

   logic                advance;
   logic                rsp_fire;
   logic                grp_done;
   logic [TILE_W-1:0]   old_tx, old_ty, new_tx, new_ty;
   axis_cfg_type        cfg_x, cfg_y;
   kind_type            kind;

   assign cfg_x = '{near_margin: margin_left_ff, far_margin: margin_right_ff,
                    map_tiles: map_width_ff};
   assign cfg_y = '{near_margin: margin_top_ff, far_margin: margin_bottom_ff,
                    map_tiles: map_height_ff};

   dzst_axis #(.SCREEN(SCREEN_W), .OFFSET(OFFSET_X)) u_axis_x (
      .pix      (in_x_ff[COORD_W-1:COORD_W-PIX_W]),
      .cam      (cam_x_ff),
      .cfg      (cfg_x),
      .cam_next (cam_x_in)
   );

   dzst_axis #(.SCREEN(SCREEN_H), .OFFSET(OFFSET_Y)) u_axis_y (
      .pix      (in_y_ff[COORD_W-1:COORD_W-PIX_W]),
      .cam      (cam_y_ff),
      .cfg      (cfg_y),
      .cam_next (cam_y_in)
   );

   assign old_tx = cam_x_ff[SCROLL_W-1:3];
   assign old_ty = cam_y_ff[SCROLL_W-1:3];
   assign new_tx = cam_x_in[SCROLL_W-1:3];
   assign new_ty = cam_y_in[SCROLL_W-1:3];

   assign load_col_in = (new_tx > old_tx) ? new_tx + EDGE_COL_ADD : new_tx;
   assign load_row_in = (new_ty > old_ty) ? new_ty + EDGE_ROW_ADD : new_ty;

   assign rsp_fire  = rsp.valid && rsp.ready;
   assign grp_done  = rsp_fire && !col_pend_ff && !row_pend_ff;
   assign advance   = in_valid_ff && (!grp_valid_ff || grp_done);
   assign req.ready = !in_valid_ff || advance;

   // configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_left_ff   <= MARGIN_RESET;
         margin_right_ff  <= MARGIN_RESET;
         margin_top_ff    <= MARGIN_RESET;
         margin_bottom_ff <= MARGIN_RESET;
         map_width_ff     <= MAP_RESET;
         map_height_ff    <= MAP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_MARGIN_LEFT:   margin_left_ff   <= csr_wdata;
            REG_MARGIN_RIGHT:  margin_right_ff  <= csr_wdata;
            REG_MARGIN_TOP:    margin_top_ff    <= csr_wdata;
            REG_MARGIN_BOTTOM: margin_bottom_ff <= csr_wdata;
            REG_MAP_WIDTH:     map_width_ff     <= csr_wdata;
            REG_MAP_HEIGHT:    map_height_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         grp_valid_ff <= 1'b0;
         col_pend_ff  <= 1'b0;
         row_pend_ff  <= 1'b0;
         cam_x_ff     <= '0;
         cam_y_ff     <= '0;
      end else begin
         if (req.valid && req.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            // load the next group and commit the new scroll
            grp_valid_ff <= 1'b1;
            col_pend_ff  <= (new_tx != old_tx);
            row_pend_ff  <= (new_ty != old_ty);
            cam_x_ff     <= cam_x_in;
            cam_y_ff     <= cam_y_in;
         end else if (rsp_fire) begin
            if (col_pend_ff) begin
               col_pend_ff <= 1'b0;
            end else if (row_pend_ff) begin
               row_pend_ff <= 1'b0;
            end else begin
               grp_valid_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_x_ff <= req.world_x;
         in_y_ff <= req.world_y;
      end
      if (advance) begin
         load_col_ff <= load_col_in;
         load_row_ff <= load_row_in;
      end
   end

   always_comb begin
      if (col_pend_ff) begin
         kind = KIND_COLUMN;
      end else if (row_pend_ff) begin
         kind = KIND_ROW;
      end else begin
         kind = KIND_SCROLL;
      end
   end

   always_comb begin
      rsp.valid       = grp_valid_ff;
      rsp.result_kind = kind;
      rsp.region_col  = '0;
      rsp.region_row  = '0;
      rsp.region_cols = '0;
      rsp.region_rows = '0;
      rsp.scroll_x    = '0;
      rsp.scroll_y    = '0;
      rsp.last        = 1'b0;
      case (kind)
         KIND_COLUMN: begin
            rsp.region_col  = load_col_ff;
            rsp.region_row  = cam_y_ff[SCROLL_W-1:3];
            rsp.region_cols = UNIT_SPAN;
            rsp.region_rows = COLUMN_ROWS;
         end
         KIND_ROW: begin
            rsp.region_col  = cam_x_ff[SCROLL_W-1:3];
            rsp.region_row  = load_row_ff;
            rsp.region_cols = ROW_COLS;
            rsp.region_rows = UNIT_SPAN;
         end
         KIND_SCROLL: begin
            rsp.scroll_x = cam_x_ff;
            rsp.scroll_y = cam_y_ff;
            rsp.last     = 1'b1;
         end
         default: ;
      endcase
   end

   // scroll holds between group loads
   `DZST_ASSERT_NEXT(a_cam_hold, clock, reset, !advance, $stable(cam_x_ff) && $stable(cam_y_ff), "scroll changed without a group load")
   // a full input register only refills when it empties the same cycle
   `DZST_ASSERT_NOW(a_refill, clock, reset, req.valid && req.ready && in_valid_ff, advance, "input register overwritten")
   // pending loads only inside a live group
   `DZST_ASSERT_NOW(a_pend_in_grp, clock, reset, col_pend_ff || row_pend_ff, grp_valid_ff, "load pending with no group")
   // the final result of a group carries the committed scroll
   `DZST_ASSERT_NOW(a_last_scroll, clock, reset, rsp.valid && rsp.last, rsp.scroll_x == cam_x_ff && rsp.scroll_y == cam_y_ff, "final result scroll mismatch")

endmodule
